/* rtl/mbtcp_pkg.sv */
`timescale 1ns / 1ps
// shared types, codes and constants of the modbus tcp read client framer
// no dependencies; imported by modbus_tcp_read_client_framer

package mbtcp_pkg;

    localparam int unsigned MAX_FRAME = 260;
    localparam int unsigned MAX_REGS  = 124;

    // largest length field that still fits the frame limit with the 6 byte prefix
    localparam logic [15:0] MAX_LEN_FIELD = 16'(MAX_FRAME - 6);
    localparam logic [15:0] MAX_REG_COUNT = 16'(MAX_REGS);

    localparam logic [7:0] FC_READ_HOLDING = 8'h03;
    localparam logic [7:0] FC_READ_INPUT   = 8'h04;
    localparam logic [7:0] FC_EXC_FLAG     = 8'h80;
    localparam logic [15:0] REQ_LEN_FIELD  = 16'h0006;

    localparam logic [15:0] UNIT_ID_RESET      = 16'h0001;
    localparam logic [15:0] REGION_FIRST_RESET = 16'h0006;
    localparam logic [15:0] REGION_LAST_RESET  = 16'h01D9;

    // configuration register indexes
    localparam logic [1:0] CFG_UNIT_ID      = 2'd0;
    localparam logic [1:0] CFG_REGION_FIRST = 2'd1;
    localparam logic [1:0] CFG_REGION_LAST  = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_REQ_BYTE = 2'd0;
    localparam logic [1:0] KIND_MEAS     = 2'd1;
    localparam logic [1:0] KIND_STATUS   = 2'd2;

    // status codes
    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_BAD_REQ   = 4'd1;
    localparam logic [3:0] ST_LEN_LT2   = 4'd2;
    localparam logic [3:0] ST_TOO_BIG   = 4'd3;
    localparam logic [3:0] ST_TID       = 4'd4;
    localparam logic [3:0] ST_PROTO     = 4'd5;
    localparam logic [3:0] ST_LEN_LT3   = 4'd6;
    localparam logic [3:0] ST_UNIT      = 4'd7;
    localparam logic [3:0] ST_EXCEPTION = 4'd8;
    localparam logic [3:0] ST_FC        = 4'd9;
    localparam logic [3:0] ST_COUNT     = 4'd10;
    localparam logic [3:0] ST_SHORT     = 4'd11;

    localparam logic [3:0] REQ_LAST_BEAT = 4'd11;

    typedef struct packed {
        logic        operation;
        logic [7:0]  func_code;
        logic [15:0] start_address;
        logic [15:0] register_count;
        logic [7:0]  rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  tx_byte;
        logic [31:0] measurement;
        logic [3:0]  status;
        logic [7:0]  exception_code;
        logic        last;
    } out_item_t;

    typedef enum logic [1:0] {
        PH_IDLE = 2'b01,
        PH_RECV = 2'b10
    } phase_t;

    typedef enum logic [1:0] {
        BK_REQ,
        BK_STAT,
        BK_WORD,
        BK_WORD_STAT
    } bundle_kind_t;

    // byte of the 12 byte read request by position
    function automatic logic [7:0] req_byte(
        input logic [3:0]  idx,
        input logic [15:0] tid,
        input logic [7:0]  unit,
        input logic [7:0]  fc,
        input logic [15:0] sa,
        input logic [15:0] cnt
    );
        logic [7:0] b;
        begin
            unique case (idx)
                4'd0:    b = tid[15:8];
                4'd1:    b = tid[7:0];
                4'd4:    b = REQ_LEN_FIELD[15:8];
                4'd5:    b = REQ_LEN_FIELD[7:0];
                4'd6:    b = unit;
                4'd7:    b = fc;
                4'd8:    b = sa[15:8];
                4'd9:    b = sa[7:0];
                4'd10:   b = cnt[15:8];
                4'd11:   b = cnt[7:0];
                default: b = 8'h00;
            endcase
            return b;
        end
    endfunction

endpackage

/* rtl/modbus_tcp_read_client_framer.sv */
`timescale 1ns / 1ps
// modbus tcp read registers client framer: request builder and response parser
// depends on mbtcp_pkg
//
// usage
//   s_ channel: one beat is either a read request (operation 0) or one received
//   response byte (operation 1). m_ channel: result beats, last set on the final
//   result caused by one input beat. cfg_ channel: cfg_index 0 unit id,
//   1 region first, 2 region last; cfg_ready is always high.
// dataflow and throughput
//   an input beat sits in the input register, is processed in one pass and its
//   results are held in the result register, which hands them out one beat at a
//   time. response bytes go at one per cycle while the result register is empty
//   or its last beat is being taken; while results are held, the next input beat
//   is taken only when the last of them is accepted.
//   bytes that yield no result never occupy the result register.
// reset
//   aresetn (sync, low) loads the configuration defaults (unit 1, region 6..473),
//   zeroes the transaction counter and leaves the parser idle.
// stall
//   when m_ready is low the result register holds; the input register fills and
//   s_ready drops until the held results are taken.

module modbus_tcp_read_client_framer #(
    parameter int unsigned MAX_FRAME = mbtcp_pkg::MAX_FRAME,
    parameter int unsigned MAX_REGS  = mbtcp_pkg::MAX_REGS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  mbtcp_pkg::in_item_t  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output mbtcp_pkg::out_item_t m_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [15:0]          cfg_data
);
    import mbtcp_pkg::*;

    // largest length field that fits the frame limit after the 6 byte prefix
    localparam logic [15:0] LEN_FIELD_LIMIT = 16'(MAX_FRAME - 6);
    localparam logic [15:0] REG_COUNT_LIMIT = 16'(MAX_REGS);

    // configuration
    logic [7:0]  unit_id_reg;
    logic [15:0] region_first_reg, region_last_reg;

    // input register
    logic     in_vld_reg, in_vld_next;
    in_item_t in_reg;

    // protocol state
    logic [15:0] tcnt_reg, tcnt_next;
    logic [15:0] exp_tid_reg, exp_tid_next;
    logic [7:0]  exp_fc_reg, exp_fc_next;
    logic [6:0]  exp_regs_reg, exp_regs_next;
    phase_t      phase_reg, phase_next;
    logic [8:0]  byte_idx_reg, byte_idx_next;
    logic [15:0] hdr_reg, hdr_next;
    logic [15:0] flen_reg, flen_next;
    logic [3:0]  err_reg, err_next;
    logic [23:0] wa_reg, wa_next;
    logic [5:0]  wl_reg, wl_next;

    // result register
    logic         out_vld_reg, out_vld_next;
    bundle_kind_t bk_reg, bk_next;
    logic [3:0]   beat_reg, beat_next;
    logic [15:0]  b_tid_reg, b_tid_next;
    logic [7:0]   b_unit_reg, b_unit_next;
    logic [7:0]   b_fc_reg, b_fc_next;
    logic [15:0]  b_sa_reg, b_sa_next;
    logic [15:0]  b_cnt_reg, b_cnt_next;
    logic [31:0]  b_word_reg, b_word_next;
    logic [3:0]   b_st_reg, b_st_next;
    logic [7:0]   b_exc_reg, b_exc_next;

    logic [3:0] last_beat;
    logic       out_done, take_in;
    logic       req_ok;
    logic [16:0] req_end;

    assign cfg_ready = 1'b1;

    assign last_beat = (bk_reg == BK_REQ) ? REQ_LAST_BEAT :
                       (bk_reg == BK_WORD_STAT) ? 4'd1 : 4'd0;
    assign out_done  = out_vld_reg && m_ready && (beat_reg == last_beat);
    assign take_in   = in_vld_reg && (!out_vld_reg || out_done);
    assign s_ready   = !in_vld_reg || take_in;

    assign req_end = {1'b0, in_reg.start_address} + {1'b0, in_reg.register_count};
    assign req_ok  = ((in_reg.func_code == FC_READ_HOLDING) ||
                      (in_reg.func_code == FC_READ_INPUT)) &&
                     (in_reg.register_count != 16'd0) &&
                     (in_reg.register_count <= REG_COUNT_LIMIT) &&
                     (in_reg.start_address >= region_first_reg) &&
                     (req_end <= {1'b0, region_last_reg} + 17'd1);

    always_comb begin
        logic [15:0] shifted;
        logic [7:0]  b;
        logic        emit_word, emit_stat, abort;
        logic [3:0]  abort_st;
        logic [31:0] word_v;

        tcnt_next     = tcnt_reg;
        exp_tid_next  = exp_tid_reg;
        exp_fc_next   = exp_fc_reg;
        exp_regs_next = exp_regs_reg;
        phase_next    = phase_reg;
        byte_idx_next = byte_idx_reg;
        hdr_next      = hdr_reg;
        flen_next     = flen_reg;
        err_next      = err_reg;
        wa_next       = wa_reg;
        wl_next       = wl_reg;

        bk_next     = bk_reg;
        b_tid_next  = b_tid_reg;
        b_unit_next = b_unit_reg;
        b_fc_next   = b_fc_reg;
        b_sa_next   = b_sa_reg;
        b_cnt_next  = b_cnt_reg;
        b_word_next = b_word_reg;
        b_st_next   = b_st_reg;
        b_exc_next  = b_exc_reg;

        b         = in_reg.rx_byte;
        shifted   = {hdr_reg[7:0], b};
        emit_word = 1'b0;
        emit_stat = 1'b0;
        abort     = 1'b0;
        abort_st  = ST_OK;
        word_v    = {wa_reg, b};

        if (out_done) begin
            out_vld_next = 1'b0;
            beat_next    = 4'd0;
        end else if (out_vld_reg && m_ready) begin
            out_vld_next = 1'b1;
            beat_next    = beat_reg + 4'd1;
        end else begin
            out_vld_next = out_vld_reg;
            beat_next    = beat_reg;
        end

        if (take_in) begin
            if (!in_reg.operation) begin
                out_vld_next = 1'b1;
                beat_next    = 4'd0;
                if (!req_ok) begin
                    bk_next    = BK_STAT;
                    b_st_next  = ST_BAD_REQ;
                    b_exc_next = 8'h00;
                end else begin
                    tcnt_next     = tcnt_reg + 16'd1;
                    bk_next       = BK_REQ;
                    b_tid_next    = tcnt_reg + 16'd1;
                    b_unit_next   = unit_id_reg;
                    b_fc_next     = in_reg.func_code;
                    b_sa_next     = in_reg.start_address;
                    b_cnt_next    = in_reg.register_count;
                    exp_tid_next  = tcnt_reg + 16'd1;
                    exp_fc_next   = in_reg.func_code;
                    exp_regs_next = in_reg.register_count[6:0];
                    phase_next    = PH_RECV;
                    byte_idx_next = 9'd0;
                    hdr_next      = 16'd0;
                    flen_next     = 16'd0;
                    err_next      = ST_OK;
                    wa_next       = 24'd0;
                    wl_next       = 6'd0;
                end
            end else if (phase_reg == PH_RECV) begin
                if (byte_idx_reg < 9'd7) begin
                    hdr_next = shifted;
                end
                priority if (byte_idx_reg == 9'd1) begin
                    if (shifted != exp_tid_reg && err_reg == ST_OK) err_next = ST_TID;
                end else if (byte_idx_reg == 9'd3) begin
                    if (shifted != 16'd0 && err_reg == ST_OK) err_next = ST_PROTO;
                end else if (byte_idx_reg == 9'd5) begin
                    flen_next = shifted;
                    if (shifted < 16'd2 || shifted > LEN_FIELD_LIMIT) begin
                        abort    = 1'b1;
                        abort_st = (shifted < 16'd2) ? ST_LEN_LT2 : ST_TOO_BIG;
                    end else if (shifted < 16'd3 && err_reg == ST_OK) begin
                        err_next = ST_LEN_LT3;
                    end
                end else if (byte_idx_reg == 9'd6) begin
                    if (b != unit_id_reg && err_reg == ST_OK) err_next = ST_UNIT;
                end else if (byte_idx_reg == 9'd7) begin
                    if (err_reg == ST_OK) begin
                        if (b == (exp_fc_reg | FC_EXC_FLAG)) err_next = ST_EXCEPTION;
                        else if (b != exp_fc_reg)            err_next = ST_FC;
                    end
                end else if (byte_idx_reg == 9'd8) begin
                    if (err_reg == ST_EXCEPTION) begin
                        wa_next = {16'd0, b};
                    end else if (err_reg == ST_OK) begin
                        if (b != {exp_regs_reg, 1'b0}) begin
                            err_next = ST_COUNT;
                        end else if (flen_reg - 16'd3 < {8'd0, b}) begin
                            err_next = ST_SHORT;
                        end else begin
                            wl_next = b[7:2];
                            wa_next = 24'd0;
                        end
                    end
                end else begin
                    // data bytes: every fourth one completes a register pair
                    if (byte_idx_reg >= 9'd9 && err_reg == ST_OK && wl_reg != 6'd0) begin
                        if (byte_idx_reg[1:0] == 2'b00) begin
                            emit_word = 1'b1;
                            wa_next   = 24'd0;
                            wl_next   = wl_reg - 6'd1;
                        end else begin
                            wa_next = {wa_reg[15:0], b};
                        end
                    end
                end

                if (abort) begin
                    phase_next    = PH_IDLE;
                    byte_idx_next = 9'd0;
                end else if (byte_idx_reg >= 9'd6 &&
                             {8'd0, byte_idx_reg} == {1'b0, flen_reg} + 17'd5) begin
                    emit_stat     = 1'b1;
                    phase_next    = PH_IDLE;
                    byte_idx_next = 9'd0;
                end else begin
                    byte_idx_next = byte_idx_reg + 9'd1;
                end

                if (abort) begin
                    out_vld_next = 1'b1;
                    beat_next    = 4'd0;
                    bk_next      = BK_STAT;
                    b_st_next    = abort_st;
                    b_exc_next   = 8'h00;
                end else if (emit_word || emit_stat) begin
                    out_vld_next = 1'b1;
                    beat_next    = 4'd0;
                    bk_next      = emit_word ? (emit_stat ? BK_WORD_STAT : BK_WORD)
                                             : BK_STAT;
                    b_word_next  = word_v;
                    b_st_next    = err_next;
                    b_exc_next   = (err_next == ST_EXCEPTION) ? wa_next[7:0] : 8'h00;
                end
            end
        end

        if (s_valid && s_ready) in_vld_next = 1'b1;
        else if (take_in)       in_vld_next = 1'b0;
        else                    in_vld_next = in_vld_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            unit_id_reg      <= UNIT_ID_RESET[7:0];
            region_first_reg <= REGION_FIRST_RESET;
            region_last_reg  <= REGION_LAST_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_UNIT_ID:      unit_id_reg      <= cfg_data[7:0];
                CFG_REGION_FIRST: region_first_reg <= cfg_data;
                CFG_REGION_LAST:  region_last_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg   <= 1'b0;
            out_vld_reg  <= 1'b0;
            beat_reg     <= 4'd0;
            tcnt_reg     <= 16'd0;
            exp_tid_reg  <= 16'd0;
            exp_fc_reg   <= 8'd0;
            exp_regs_reg <= 7'd0;
            phase_reg    <= PH_IDLE;
            byte_idx_reg <= 9'd0;
            hdr_reg      <= 16'd0;
            flen_reg     <= 16'd0;
            err_reg      <= ST_OK;
            wa_reg       <= 24'd0;
            wl_reg       <= 6'd0;
            bk_reg       <= BK_STAT;
        end else begin
            in_vld_reg   <= in_vld_next;
            out_vld_reg  <= out_vld_next;
            beat_reg     <= beat_next;
            tcnt_reg     <= tcnt_next;
            exp_tid_reg  <= exp_tid_next;
            exp_fc_reg   <= exp_fc_next;
            exp_regs_reg <= exp_regs_next;
            phase_reg    <= phase_next;
            byte_idx_reg <= byte_idx_next;
            hdr_reg      <= hdr_next;
            flen_reg     <= flen_next;
            err_reg      <= err_next;
            wa_reg       <= wa_next;
            wl_reg       <= wl_next;
            bk_reg       <= bk_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) in_reg <= s_data;
        b_tid_reg  <= b_tid_next;
        b_unit_reg <= b_unit_next;
        b_fc_reg   <= b_fc_next;
        b_sa_reg   <= b_sa_next;
        b_cnt_reg  <= b_cnt_next;
        b_word_reg <= b_word_next;
        b_st_reg   <= b_st_next;
        b_exc_reg  <= b_exc_next;
    end

    // result beat selection
    always_comb begin
        m_valid        = out_vld_reg;
        m_data.last    = (beat_reg == last_beat);
        m_data.tx_byte = 8'h00;
        m_data.measurement    = 32'd0;
        m_data.status         = ST_OK;
        m_data.exception_code = 8'h00;
        unique case (bk_reg)
            BK_REQ: begin
                m_data.kind    = KIND_REQ_BYTE;
                m_data.tx_byte = req_byte(beat_reg, b_tid_reg, b_unit_reg, b_fc_reg,
                                          b_sa_reg, b_cnt_reg);
            end
            BK_WORD, BK_WORD_STAT: begin
                if (beat_reg == 4'd0) begin
                    m_data.kind        = KIND_MEAS;
                    m_data.measurement = b_word_reg;
                end else begin
                    m_data.kind           = KIND_STATUS;
                    m_data.status         = b_st_reg;
                    m_data.exception_code = b_exc_reg;
                end
            end
            default: begin
                m_data.kind           = KIND_STATUS;
                m_data.status         = b_st_reg;
                m_data.exception_code = b_exc_reg;
            end
        endcase
    end

    a_beat_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_vld_reg |-> (beat_reg <= last_beat))
        else $error("result beat counter past end of bundle");

    a_idle_index_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_IDLE) |-> (byte_idx_reg == 9'd0))
        else $error("byte index not cleared while parser idle");

    a_req_tid_current: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_vld_reg && bk_reg == BK_REQ) |-> (b_tid_reg == tcnt_reg))
        else $error("request frame carries stale transaction id");

    a_empty_input_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_vld_reg |-> s_ready)
        else $error("input register empty but not ready");

    a_stall_holds_bundle: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_vld_reg && !m_ready) |=> (out_vld_reg && $stable(beat_reg)))
        else $error("result bundle changed while stalled");

endmodule

/* tb/sv/tb_modbus_tcp_read_client_framer.sv */
`timescale 1ns / 1ps
// self-checking testbench for modbus_tcp_read_client_framer: read requests and reply frames,
// directed then random, with every result beat compared against an in-bench model
// depends on mbtcp_pkg and the framer rtl

module tb_modbus_tcp_read_client_framer;
    import mbtcp_pkg::*;

    localparam logic OP_REQUEST   = 1'b0;
    localparam logic OP_RX_BYTE   = 1'b1;
    localparam int   QUIET_LIMIT  = 2000;
    localparam int   DRAIN_CYCLES = 8;

    // ways a reply frame can be spoiled
    typedef enum int {
        F_NONE, F_TID, F_PROTO, F_LEN_TINY, F_LEN_TWO, F_LEN_HUGE, F_UNIT,
        F_EXC, F_FC, F_COUNT, F_SHORT, F_EXTRA, F_CUT, F_MULTI
    } reply_flaw_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    in_item_t    s_data;
    logic        m_valid;
    logic        m_ready;
    out_item_t   m_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    // framer model state
    logic [7:0]  unit_sel    = UNIT_ID_RESET[7:0];
    logic [15:0] window_lo   = REGION_FIRST_RESET;
    logic [15:0] window_hi   = REGION_LAST_RESET;
    logic [15:0] tid_counter = '0;
    logic [15:0] want_tid    = '0;
    logic [7:0]  want_fc     = '0;
    logic [6:0]  want_regs   = '0;
    logic        receiving   = 1'b0;
    logic [8:0]  rx_index    = '0;
    logic [63:0] hdr         = '0;
    logic [15:0] frame_len   = '0;
    logic [3:0]  fault       = ST_OK;
    logic [23:0] word_acc    = '0;
    logic [5:0]  words_left  = '0;

    out_item_t framer_out_q[$];
    int        fail_count = 0;
    int        items_sent = 0;
    int        quiet      = 0;
    bit        idle_on    = 1'b1;

    modbus_tcp_read_client_framer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // result side back-pressure
    initial begin : sink_stall
        m_ready <= 1'b1;
        forever begin
            @(posedge aclk);
            if (idle_on && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
                m_ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    function automatic out_item_t framer_result(input logic [1:0] kind, input logic [7:0] tx,
                                                input logic [31:0] meas, input logic [3:0] st,
                                                input logic [7:0] exc);
        out_item_t r;
        r.kind           = kind;
        r.tx_byte        = tx;
        r.measurement    = meas;
        r.status         = st;
        r.exception_code = exc;
        r.last           = 1'b0;
        return r;
    endfunction

    // works out the result beats of one accepted input beat
    task automatic model_framer(input in_item_t it);
        out_item_t  res[$];
        out_item_t  tail;
        logic [7:0] req[12];
        logic [7:0] b;
        int         idx;
        int         top_addr;
        bit         ok;
        bit         dropped;
        dropped = 1'b0;
        if (it.operation == OP_REQUEST) begin
            top_addr = int'(it.start_address) + int'(it.register_count) - 1;
            ok = (it.func_code == FC_READ_HOLDING || it.func_code == FC_READ_INPUT) &&
                 it.register_count != 16'd0 && it.register_count <= MAX_REG_COUNT &&
                 it.start_address >= window_lo && top_addr <= int'(window_hi);
            if (!ok) begin
                res.push_back(framer_result(KIND_STATUS, 8'h00, 32'h0, ST_BAD_REQ, 8'h00));
            end else begin
                tid_counter = tid_counter + 16'd1;
                req = '{tid_counter[15:8], tid_counter[7:0], 8'h00, 8'h00,
                        REQ_LEN_FIELD[15:8], REQ_LEN_FIELD[7:0], unit_sel, it.func_code,
                        it.start_address[15:8], it.start_address[7:0],
                        it.register_count[15:8], it.register_count[7:0]};
                foreach (req[i])
                    res.push_back(framer_result(KIND_REQ_BYTE, req[i], 32'h0, ST_OK, 8'h00));
                want_tid   = tid_counter;
                want_fc    = it.func_code;
                want_regs  = it.register_count[6:0];
                receiving  = 1'b1;
                rx_index   = '0;
                hdr        = '0;
                frame_len  = '0;
                fault      = ST_OK;
                word_acc   = '0;
                words_left = '0;
            end
        end else if (receiving) begin
            b   = it.rx_byte;
            idx = int'(rx_index);
            if (idx < 7)
                hdr = {hdr[55:0], b};
            if (idx == 1) begin
                if (hdr[15:0] != want_tid && fault == ST_OK)
                    fault = ST_TID;
            end else if (idx == 3) begin
                if (hdr[15:0] != 16'h0000 && fault == ST_OK)
                    fault = ST_PROTO;
            end else if (idx == 5) begin
                frame_len = hdr[15:0];
                // bad length is reported at once, without waiting for frame end
                if (frame_len < 16'd2 || frame_len > MAX_LEN_FIELD) begin
                    res.push_back(framer_result(KIND_STATUS, 8'h00, 32'h0,
                                                frame_len < 16'd2 ? ST_LEN_LT2 : ST_TOO_BIG,
                                                8'h00));
                    receiving = 1'b0;
                    rx_index  = '0;
                    dropped   = 1'b1;
                end else if (frame_len < 16'd3 && fault == ST_OK) begin
                    fault = ST_LEN_LT3;
                end
            end else if (idx == 6) begin
                if (b != unit_sel && fault == ST_OK)
                    fault = ST_UNIT;
            end else if (idx == 7) begin
                if (fault == ST_OK) begin
                    if (b == (want_fc | FC_EXC_FLAG))
                        fault = ST_EXCEPTION;
                    else if (b != want_fc)
                        fault = ST_FC;
                end
            end else if (idx == 8) begin
                if (fault == ST_EXCEPTION) begin
                    word_acc = {16'h0000, b};
                end else if (fault == ST_OK) begin
                    if (int'(b) != int'(want_regs) * 2)
                        fault = ST_COUNT;
                    else if (int'(frame_len) - 3 < int'(b))
                        fault = ST_SHORT;
                    else begin
                        words_left = 6'(b / 4);
                        word_acc   = '0;
                    end
                end
            end else if (idx >= 9) begin
                if (fault == ST_OK && words_left != 6'd0) begin
                    if (((idx - 9) % 4) == 3) begin
                        res.push_back(framer_result(KIND_MEAS, 8'h00, {word_acc, b}, ST_OK,
                                                    8'h00));
                        word_acc   = '0;
                        words_left = words_left - 6'd1;
                    end else begin
                        word_acc = {word_acc[15:0], b};
                    end
                end
            end
            if (!dropped) begin
                if (idx >= 6 && idx == 5 + int'(frame_len)) begin
                    res.push_back(framer_result(KIND_STATUS, 8'h00, 32'h0, fault,
                                                fault == ST_EXCEPTION ? word_acc[7:0] : 8'h00));
                    receiving = 1'b0;
                    rx_index  = '0;
                end else begin
                    rx_index = 9'(idx + 1);
                end
            end
        end
        if (res.size() != 0) begin
            tail      = res.pop_back();
            tail.last = 1'b1;
            res.push_back(tail);
        end
        foreach (res[i])
            framer_out_q.push_back(res[i]);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin : result_check
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (framer_out_q.size() == 0) begin
                $error("result beat with nothing outstanding: %p", m_data);
                fail_count++;
            end else begin
                want = framer_out_q.pop_front();
                check_field("kind", 32'(want.kind), 32'(m_data.kind));
                check_field("tx_byte", 32'(want.tx_byte), 32'(m_data.tx_byte));
                check_field("measurement", want.measurement, m_data.measurement);
                check_field("status", 32'(want.status), 32'(m_data.status));
                check_field("exception_code", 32'(want.exception_code),
                            32'(m_data.exception_code));
                check_field("last", 32'(want.last), 32'(m_data.last));
            end
        end
    end

    // valid is left high after a beat so back-to-back beats need no toggle
    task automatic send_item(input in_item_t it);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        model_framer(it);
        items_sent++;
    endtask

    task automatic send_request(input logic [7:0] fc, input logic [15:0] sa,
                                input logic [15:0] cnt);
        in_item_t it;
        it.operation      = OP_REQUEST;
        it.func_code      = fc;
        it.start_address  = sa;
        it.register_count = cnt;
        it.rx_byte        = 8'($urandom);
        send_item(it);
    endtask

    task automatic send_rx(input logic [7:0] b);
        in_item_t it;
        it.operation      = OP_RX_BYTE;
        it.func_code      = 8'($urandom);
        it.start_address  = 16'($urandom);
        it.register_count = 16'($urandom);
        it.rx_byte        = b;
        send_item(it);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (framer_out_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_config(input logic [7:0] unit, input logic [15:0] lo,
                                input logic [15:0] hi);
        logic [15:0] vals[3];
        logic [1:0]  regs[3];
        wait_idle();
        vals = '{{8'($urandom), unit}, lo, hi};
        regs = '{CFG_UNIT_ID, CFG_REGION_FIRST, CFG_REGION_LAST};
        cfg_valid <= 1'b1;
        for (int i = 0; i < 3; i++) begin
            cfg_index <= regs[i];
            cfg_data  <= vals[i];
            do @(posedge aclk); while (!cfg_ready);
            case (regs[i])
                CFG_UNIT_ID:      unit_sel  = vals[i][7:0];
                CFG_REGION_FIRST: window_lo = vals[i];
                CFG_REGION_LAST:  window_hi = vals[i];
                default: ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    // request inside the current address window, mostly short ones
    task automatic send_good_request(output bit sent);
        int span;
        int cnt;
        int sa;
        sent = 1'b0;
        span = int'(window_hi) - int'(window_lo) + 1;
        if (span > 0) begin
            cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12)
                                              : $urandom_range(1, 4);
            if (cnt > span)
                cnt = span;
            sa = int'(window_lo) + $urandom_range(0, span - cnt);
            send_request($urandom_range(0, 1) ? FC_READ_INPUT : FC_READ_HOLDING, 16'(sa),
                         16'(cnt));
            sent = 1'b1;
        end
    endtask

    // reply to the outstanding request, spoiled as asked
    task automatic send_reply(input reply_flaw_t flaw);
        logic [7:0]  frm[$];
        logic [15:0] tid;
        logic [15:0] proto;
        logic [15:0] len;
        logic [7:0]  unit;
        logic [7:0]  fc;
        logic [7:0]  bc;
        int          n_data;
        int          keep;
        tid    = want_tid;
        proto  = '0;
        unit   = unit_sel;
        fc     = want_fc;
        bc     = 8'(int'(want_regs) * 2);
        n_data = int'(bc);
        case (flaw)
            F_TID:   tid ^= 16'($urandom_range(1, 65535));
            F_PROTO: proto = 16'($urandom_range(1, 65535));
            F_UNIT:  unit ^= 8'($urandom_range(1, 255));
            F_EXC: begin
                fc     = want_fc | FC_EXC_FLAG;
                bc     = 8'($urandom);
                n_data = $urandom_range(0, 3);
            end
            F_FC:    do fc = 8'($urandom); while (fc == want_fc || fc == (want_fc | FC_EXC_FLAG));
            F_COUNT: do bc = 8'($urandom); while (bc == 8'(int'(want_regs) * 2));
            F_SHORT: n_data = n_data - $urandom_range(1, n_data);
            F_EXTRA: n_data = n_data + $urandom_range(1, (n_data > 247) ? 251 - n_data : 4);
            F_MULTI: begin
                tid  ^= 16'($urandom_range(1, 65535));
                unit ^= 8'($urandom_range(1, 255));
                fc    = ~want_fc;
            end
            default: ;
        endcase
        len = 16'(3 + n_data);
        if (flaw == F_LEN_TINY)
            len = 16'($urandom_range(0, 1));
        if (flaw == F_LEN_TWO)
            len = 16'd2;
        if (flaw == F_LEN_HUGE)
            len = $urandom_range(0, 1) ? MAX_LEN_FIELD + 16'd1
                                       : 16'($urandom_range(int'(MAX_LEN_FIELD) + 1, 65535));
        frm = '{tid[15:8], tid[7:0], proto[15:8], proto[7:0], len[15:8], len[7:0]};
        if (len >= 16'd2 && len <= MAX_LEN_FIELD) begin
            frm.push_back(unit);
            frm.push_back(fc);
            if (len >= 16'd3) begin
                frm.push_back(bc);
                repeat (int'(len) - 3) frm.push_back(8'($urandom));
            end
        end
        // frame abandoned part way; the next good request drops it
        if (flaw == F_CUT) begin
            keep = $urandom_range(1, frm.size() - 1);
            while (frm.size() > keep) void'(frm.pop_back());
        end
        foreach (frm[i])
            send_rx(frm[i]);
    endtask

    function automatic reply_flaw_t pick_flaw();
        if ($urandom_range(0, 9) < 6)
            return F_NONE;
        return reply_flaw_t'($urandom_range(int'(F_TID), int'(F_MULTI)));
    endfunction

    task automatic run_traffic(input int n);
        int stop_at;
        int pick;
        bit sent;
        stop_at = items_sent + n;
        while (items_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
                send_good_request(sent);
                if (sent)
                    send_reply(pick_flaw());
                else
                    send_request(8'($urandom), 16'($urandom), 16'($urandom));
            end else if (pick < 87) begin
                send_request(8'($urandom), 16'($urandom), 16'($urandom));
            end else if (pick < 95) begin
                repeat ($urandom_range(1, 6)) send_rx(8'($urandom));
            end else begin
                send_request(FC_READ_HOLDING, window_lo,
                             $urandom_range(0, 1) ? 16'd0 : MAX_REG_COUNT + 16'd1);
            end
        end
    endtask

    task automatic test_request_checks();
        send_request(FC_READ_HOLDING, REGION_FIRST_RESET, 16'd1);
        send_reply(F_NONE);
        // largest request; it gets no reply and the next request replaces it
        send_request(FC_READ_INPUT, REGION_LAST_RESET - MAX_REG_COUNT + 16'd1, MAX_REG_COUNT);
        send_request(FC_READ_HOLDING, REGION_LAST_RESET, 16'd1);
        send_reply(F_EXTRA);
        send_request(8'h00, 16'd100, 16'd4);
        send_request(8'hFF, 16'd100, 16'd4);
        send_request(FC_READ_HOLDING | FC_EXC_FLAG, 16'd100, 16'd4);
        send_request(FC_READ_INPUT + 8'd1, 16'd100, 16'd4);
        send_request(FC_READ_HOLDING, 16'd100, 16'd0);
        send_request(FC_READ_INPUT, 16'd100, MAX_REG_COUNT + 16'd1);
        send_request(FC_READ_HOLDING, 16'd100, 16'hFFFF);
        send_request(FC_READ_HOLDING, REGION_FIRST_RESET - 16'd1, 16'd1);
        send_request(FC_READ_INPUT, REGION_LAST_RESET - 16'd1, 16'd3);
        // start plus count must not wrap back into the window
        send_request(FC_READ_HOLDING, 16'hFFFF, MAX_REG_COUNT);
    endtask

    task automatic test_reply_faults();
        bit sent;
        for (int f = int'(F_NONE); f <= int'(F_MULTI); f++) begin
            send_good_request(sent);
            send_reply(reply_flaw_t'(f));
        end
        // parser is idle here, byte is dropped
        send_rx(8'h5A);
    endtask

    task automatic test_full_window();
        write_config(8'h00, 16'h0000, 16'hFFFF);
        send_request(FC_READ_HOLDING, 16'hFFFF, 16'd1);
        send_reply(F_NONE);
        send_request(FC_READ_INPUT, 16'hFFFF, 16'd2);
        send_request(FC_READ_INPUT, 16'hFFFF - MAX_REG_COUNT + 16'd1, MAX_REG_COUNT);
        run_traffic(12);
    endtask

    task automatic test_single_address();
        write_config(8'hFF, 16'hFFFF, 16'hFFFF);
        run_traffic(8);
    endtask

    task automatic test_empty_window();
        idle_on = 1'b0;
        write_config(8'($urandom), 16'd300, 16'd200);
        run_traffic(8);
    endtask

    task automatic test_random_window();
        logic [15:0] lo;
        idle_on = 1'b1;
        lo = 16'($urandom_range(0, 4000));
        write_config(8'($urandom), lo, lo + 16'($urandom_range(0, 3000)));
        run_traffic(16);
        idle_on = 1'b0;
        run_traffic(12);
    endtask

    initial begin
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_UNIT_ID;
        cfg_data  <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        test_request_checks();
        test_reply_faults();
        test_full_window();
        test_single_address();
        test_empty_window();
        test_random_window();

        wait_idle();
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
